[rtl/btmx_pkg.sv]
// Shared types and constants for the binary trie max-XOR block.
package btmx_pkg;

  localparam int unsigned KEY_W    = 31;
  localparam int unsigned STATUS_W = 2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INS_DONE = 2'd0,
    ST_QUERY_OK = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

endpackage

[rtl/btmx_if.sv]
// Request and response channel interfaces for the binary trie max-XOR block.
interface btmx_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [btmx_pkg::KEY_W-1:0]    key_value;

  modport source (output valid, output req_type, output key_value, input ready);
  modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface btmx_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [btmx_pkg::KEY_W-1:0]    max_xor;
  logic [btmx_pkg::STATUS_W-1:0] status;

  modport source (output valid, output max_xor, output status, input ready);
  modport sink   (input valid, input max_xor, input status, output ready);
endinterface

[rtl/binary_trie_max_xor.sv]
// Binary trie max-XOR top level: request intake, trie walker, link memory, response register.
//
// Each request (insert or query) walks the trie one level per cycle from bit
// KEY_BITS-1 down to bit 0, because every level needs the child links that the
// previous level's read of the link memory returned. A query on an empty trie
// or an insert rejected for lack of nodes finishes without walking every
// level. One request is in flight at a time, and the next is taken while
// the previous response still waits in the output register. The root's
// links live in flip-flops cleared by reset, and every allocated node's
// entry is written when it is created (its new child link, else null), so
// the block needs no memory clearing pass after reset.
module binary_trie_max_xor #(
  parameter int unsigned NODE_CAPACITY = 4096,
  parameter int unsigned KEY_BITS      = 31
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  btmx_req_if.sink  req_i,
  btmx_rsp_if.source rsp_o
);

  localparam int unsigned NB = $clog2(NODE_CAPACITY);

  logic                    start;
  logic                    walk_ready;
  logic                    walk_done;
  logic                    out_free;
  logic [KEY_BITS-1:0]     start_key;
  logic [KEY_BITS-1:0]     res_xor;
  btmx_pkg::status_e       res_status;
  logic [KEY_BITS+btmx_pkg::KEY_W-1:0] kext;
  logic [KEY_BITS+btmx_pkg::KEY_W-1:0] rext;

  logic                    mem_we;
  logic [NB-1:0]           mem_waddr;
  logic [2*NB-1:0]         mem_wdata;
  logic [NB-1:0]           mem_raddr;
  logic [2*NB-1:0]         mem_rdata;

  logic                           rsp_valid_q;
  logic [btmx_pkg::KEY_W-1:0]     rsp_xor_q;
  btmx_pkg::status_e              rsp_status_q;

  assign kext      = {{KEY_BITS{1'b0}}, req_i.key_value};
  assign start_key = kext[KEY_BITS-1:0];
  assign rext      = {{btmx_pkg::KEY_W{1'b0}}, res_xor};

  assign req_i.ready = walk_ready;
  assign start       = req_i.valid && walk_ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  btmx_walk #(
    .NODE_CAPACITY(NODE_CAPACITY),
    .KEY_BITS     (KEY_BITS),
    .NB           (NB)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .start_type_i (req_i.req_type),
    .start_key_i  (start_key),
    .ready_o      (walk_ready),
    .done_o       (walk_done),
    .done_ack_i   (out_free),
    .res_xor_o    (res_xor),
    .res_status_o (res_status),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  btmx_link_ram #(
    .DEPTH(NODE_CAPACITY),
    .AW   (NB),
    .DW   (2 * NB)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q  <= 1'b0;
      rsp_xor_q    <= '0;
      rsp_status_q <= btmx_pkg::ST_INS_DONE;
    end else if (walk_done && out_free) begin
      rsp_valid_q  <= 1'b1;
      rsp_xor_q    <= rext[btmx_pkg::KEY_W-1:0];
      rsp_status_q <= res_status;
    end else if (rsp_o.ready) begin
      rsp_valid_q  <= 1'b0;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.max_xor = rsp_xor_q;
  assign rsp_o.status  = rsp_status_q;

endmodule

[rtl/btmx_link_ram.sv]
// Child-link memory: one entry per node, one write and one registered read port.
module btmx_link_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/btmx_walk.sv]
// Trie walk sequencer: one level per cycle, allocation and link write-back.
module btmx_walk #(
  parameter int unsigned NODE_CAPACITY = 4096,
  parameter int unsigned KEY_BITS      = 31,
  parameter int unsigned NB            = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    start_type_i,
  input  logic [KEY_BITS-1:0]     start_key_i,
  output logic                    ready_o,
  output logic                    done_o,
  input  logic                    done_ack_i,
  output logic [KEY_BITS-1:0]     res_xor_o,
  output btmx_pkg::status_e       res_status_o,
  output logic                    mem_we_o,
  output logic [NB-1:0]           mem_waddr_o,
  output logic [2*NB-1:0]         mem_wdata_o,
  output logic [NB-1:0]           mem_raddr_o,
  input  logic [2*NB-1:0]         mem_rdata_i
);

  localparam int unsigned NFW = NB + 1;
  localparam int unsigned SW  = NB + 2;
  localparam int unsigned LW  = $clog2(KEY_BITS + 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_ALLOC, S_FIN} state_e;

  state_e            state_q, state_d;
  logic [NB-1:0]     node_q, node_d;
  logic              at_root_q, at_root_d;
  logic [LW-1:0]     rem_q, rem_d;
  logic [KEY_BITS-1:0] ksh_q, ksh_d;
  logic [KEY_BITS-1:0] res_q, res_d;
  logic [NFW-1:0]    nf_q, nf_d;
  logic              any_q, any_d;
  logic              typ_q, typ_d;
  logic [NB-1:0]     root0_q, root0_d, root1_q, root1_d;
  btmx_pkg::status_e status_q, status_d;

  logic [2*NB-1:0]   links;
  logic [NB-1:0]     l0, l1, child_same, child_opp, nf_node;
  logic              kb;
  logic [SW-1:0]     need_end;

  always_comb begin
    links      = at_root_q ? {root1_q, root0_q} : mem_rdata_i;
    l0         = links[NB-1:0];
    l1         = links[2*NB-1:NB];
    kb         = ksh_q[KEY_BITS-1];
    child_same = kb ? l1 : l0;
    child_opp  = kb ? l0 : l1;
    nf_node    = nf_q[NB-1:0];
    need_end   = SW'(nf_q) + SW'(rem_q);

    state_d   = state_q;
    node_d    = node_q;
    at_root_d = at_root_q;
    rem_d     = rem_q;
    ksh_d     = ksh_q;
    res_d     = res_q;
    nf_d      = nf_q;
    any_d     = any_q;
    typ_d     = typ_q;
    root0_d   = root0_q;
    root1_d   = root1_q;
    status_d  = status_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = node_q;
    mem_wdata_o = '0;
    mem_raddr_o = node_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          typ_d     = start_type_i;
          ksh_d     = start_key_i;
          res_d     = '0;
          rem_d     = LW'(KEY_BITS);
          node_d    = '0;
          at_root_d = 1'b1;
          if (start_type_i == btmx_pkg::REQ_QUERY && !any_q) begin
            status_d = btmx_pkg::ST_EMPTY;
            state_d  = S_FIN;
          end else begin
            state_d  = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (rem_q == '0) begin
          status_d = (typ_q == btmx_pkg::REQ_QUERY) ? btmx_pkg::ST_QUERY_OK
                                                    : btmx_pkg::ST_INS_DONE;
          state_d  = S_FIN;
        end else if (typ_q == btmx_pkg::REQ_QUERY) begin
          rem_d = rem_q - 1'b1;
          ksh_d = ksh_q << 1;
          if (child_opp != '0) begin
            res_d       = (res_q << 1) | KEY_BITS'(1);
            node_d      = child_opp;
            at_root_d   = 1'b0;
            mem_raddr_o = child_opp;
          end else begin
            res_d = res_q << 1;
            if (child_same != '0) begin
              node_d      = child_same;
              at_root_d   = 1'b0;
              mem_raddr_o = child_same;
            end
          end
        end else if (child_same != '0) begin
          rem_d       = rem_q - 1'b1;
          ksh_d       = ksh_q << 1;
          node_d      = child_same;
          at_root_d   = 1'b0;
          mem_raddr_o = child_same;
        end else if (need_end > SW'(NODE_CAPACITY)) begin
          status_d = btmx_pkg::ST_FULL;
          state_d  = S_FIN;
        end else begin
          // hook the first new node onto the last existing one
          if (at_root_q) begin
            if (kb) root1_d = nf_node;
            else    root0_d = nf_node;
          end else begin
            mem_we_o    = 1'b1;
            mem_wdata_o = kb ? {nf_node, l0} : {l1, nf_node};
          end
          node_d    = nf_node;
          at_root_d = 1'b0;
          nf_d      = nf_q + 1'b1;
          rem_d     = rem_q - 1'b1;
          ksh_d     = ksh_q << 1;
          state_d   = S_ALLOC;
        end
      end
      S_ALLOC: begin
        mem_we_o = 1'b1;
        if (rem_q == '0) begin
          mem_wdata_o = '0;
          any_d       = 1'b1;
          status_d    = btmx_pkg::ST_INS_DONE;
          state_d     = S_FIN;
        end else begin
          mem_wdata_o = kb ? {nf_node, {NB{1'b0}}} : {{NB{1'b0}}, nf_node};
          node_d      = nf_node;
          nf_d        = nf_q + 1'b1;
          rem_d       = rem_q - 1'b1;
          ksh_d       = ksh_q << 1;
        end
      end
      S_FIN: begin
        if (done_ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      node_q    <= '0;
      at_root_q <= 1'b1;
      rem_q     <= '0;
      ksh_q     <= '0;
      res_q     <= '0;
      nf_q      <= NFW'(1);
      any_q     <= 1'b0;
      typ_q     <= btmx_pkg::REQ_INSERT;
      root0_q   <= '0;
      root1_q   <= '0;
      status_q  <= btmx_pkg::ST_INS_DONE;
    end else begin
      state_q   <= state_d;
      node_q    <= node_d;
      at_root_q <= at_root_d;
      rem_q     <= rem_d;
      ksh_q     <= ksh_d;
      res_q     <= res_d;
      nf_q      <= nf_d;
      any_q     <= any_d;
      typ_q     <= typ_d;
      root0_q   <= root0_d;
      root1_q   <= root1_d;
      status_q  <= status_d;
    end
  end

  assign ready_o      = (state_q == S_IDLE);
  assign done_o       = (state_q == S_FIN);
  assign res_status_o = status_q;
  assign res_xor_o    = (status_q == btmx_pkg::ST_QUERY_OK) ? res_q : '0;

endmodule

[rtl/btmx_checker.sv]
// Port-level checks for the binary trie max-XOR block, bound to the top level.
module btmx_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [btmx_pkg::KEY_W-1:0]    rsp_max_xor_i,
  input logic [btmx_pkg::STATUS_W-1:0] rsp_status_i
);

  // one request in flight: intake closes right after a request is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("intake still open after request");

  // a new response only appears as a request finishes, never while idle
  a_rsp_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> !$past(req_ready_i))
    else $error("response without a request in work");

  // only answered queries carry a nonzero result
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == btmx_pkg::ST_INS_DONE ||
                    rsp_status_i == btmx_pkg::ST_EMPTY ||
                    rsp_status_i == btmx_pkg::ST_FULL) |-> rsp_max_xor_i == '0)
    else $error("nonzero result on non-query response");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_max_xor_i) && $stable(rsp_status_i))
    else $error("stalled response changed");

endmodule

bind binary_trie_max_xor btmx_checker u_btmx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_max_xor_i (rsp_o.max_xor),
  .rsp_status_i  (rsp_o.status)
);

[sim/trie_answer_checker.sv]
// Checker for the binary trie max-XOR block: mirrors the trie and compares every response.
module trie_answer_checker #(
  parameter int unsigned NODE_CAP = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  btmx_req_if  req_i,
  btmx_rsp_if  rsp_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEY_W = btmx_pkg::KEY_W;

  typedef struct packed {
    logic [KEY_W-1:0]  max_xor;
    btmx_pkg::status_e status;
  } trie_answer_t;

  logic [11:0]  link_mem [0:2*NODE_CAP-1];
  logic [12:0]  free_node;
  logic         trie_loaded;
  trie_answer_t answer_queue [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic trie_answer_t predict_answer(input logic kind, input logic [KEY_W-1:0] key);
    trie_answer_t ans;
    int unsigned  node;
    int unsigned  need;
    int unsigned  fresh;
    int           lvl;
    logic         want;
    ans.max_xor = '0;
    node = 0;
    if (kind == btmx_pkg::REQ_INSERT) begin
      lvl = KEY_W - 1;
      while (lvl >= 0) begin
        if (link_mem[2*node + key[lvl]] == '0) break;
        node = link_mem[2*node + key[lvl]];
        lvl--;
      end
      need = lvl + 1;
      if (free_node > NODE_CAP || need > NODE_CAP - free_node) begin
        ans.status = btmx_pkg::ST_FULL;
      end else begin
        while (lvl >= 0) begin
          fresh = free_node;
          free_node++;
          link_mem[2*node + key[lvl]] = fresh[11:0];
          link_mem[2*fresh]           = '0;
          link_mem[2*fresh + 1]       = '0;
          node = fresh;
          lvl--;
        end
        trie_loaded = 1'b1;
        ans.status  = btmx_pkg::ST_INS_DONE;
      end
    end else if (!trie_loaded) begin
      ans.status = btmx_pkg::ST_EMPTY;
    end else begin
      for (lvl = KEY_W - 1; lvl >= 0; lvl--) begin
        want = ~key[lvl];
        if (link_mem[2*node + want] != '0) begin
          ans.max_xor[lvl] = 1'b1;
          node = link_mem[2*node + want];
        end else if (link_mem[2*node + !want] != '0) begin
          node = link_mem[2*node + !want];
        end
      end
      ans.status = btmx_pkg::ST_QUERY_OK;
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    trie_answer_t exp_ans;
    if (!rst_ni) begin
      for (int i = 0; i < 2*NODE_CAP; i++) link_mem[i] = '0;
      free_node   = 13'd1;
      trie_loaded = 1'b0;
      answer_queue.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      // response first: it can never belong to a request taken at this edge
      if (rsp_i.valid && rsp_i.ready) begin
        if (answer_queue.size() == 0) begin
          report_mismatch($sformatf("response with none outstanding: status %0d max_xor %h",
                                    rsp_i.status, rsp_i.max_xor));
        end else begin
          exp_ans = answer_queue.pop_front();
          if (rsp_i.status !== exp_ans.status)
            report_mismatch($sformatf("status: expected %0d, got %0d",
                                      exp_ans.status, rsp_i.status));
          if (rsp_i.max_xor !== exp_ans.max_xor)
            report_mismatch($sformatf("max_xor: expected %h, got %h",
                                      exp_ans.max_xor, rsp_i.max_xor));
        end
      end
      if (req_i.valid && req_i.ready)
        answer_queue.insert(answer_queue.size(),
                            predict_answer(req_i.req_type, req_i.key_value));
      pending_o = answer_queue.size();
    end
  end

endmodule

[sim/testbench.sv]
// Top of the binary trie max-XOR testbench: clock, reset, request stimulus, response stalls, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODE_CAP   = 4096;
  localparam int          RAND_ITEMS = 800;
  localparam int unsigned KEY_W      = btmx_pkg::KEY_W;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;

  btmx_req_if req_bus ();
  btmx_rsp_if rsp_bus ();

  binary_trie_max_xor #(
    .NODE_CAPACITY(NODE_CAP),
    .KEY_BITS     (KEY_W)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  trie_answer_checker #(
    .NODE_CAP(NODE_CAP)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_bus),
    .rsp_i       (rsp_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("binary_trie_max_xor: mismatch");
    $finish;
  end

  // response stalls: segments of always-ready, coin-flip, or long holds
  int stall_mode;
  int seg_left;
  int stall_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_mode = 0;
      seg_left   = 0;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        seg_left   = $urandom_range(50, 300);
      end else begin
        seg_left--;
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: rsp_bus.ready <= 1'b1;
          1: rsp_bus.ready <= 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 5) == 0) begin
              stall_left = $urandom_range(4, 48);
              rsp_bus.ready <= 1'b0;
            end else begin
              rsp_bus.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  task automatic send_request(input logic kind, input logic [KEY_W-1:0] key);
    req_bus.valid     <= 1'b1;
    req_bus.req_type  <= kind;
    req_bus.key_value <= key;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  task automatic drain_answers();
    req_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    logic [KEY_W-1:0] key_pool [$];
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] low_mask;
    logic             kind;
    int               sent;
    int               burst;
    int               gap;
    int               sel;

    rst_ni            <= 1'b0;
    req_bus.valid     <= 1'b0;
    req_bus.req_type  <= btmx_pkg::REQ_INSERT;
    req_bus.key_value <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty trie, extremes, duplicates, complementary patterns
    send_request(btmx_pkg::REQ_QUERY,  31'h0000_0000);
    send_request(btmx_pkg::REQ_QUERY,  31'h7FFF_FFFF);
    send_request(btmx_pkg::REQ_INSERT, 31'h0000_0000);
    send_request(btmx_pkg::REQ_QUERY,  31'h0000_0000);
    send_request(btmx_pkg::REQ_QUERY,  31'h7FFF_FFFF);
    send_request(btmx_pkg::REQ_INSERT, 31'h0000_0000);
    send_request(btmx_pkg::REQ_INSERT, 31'h7FFF_FFFF);
    send_request(btmx_pkg::REQ_QUERY,  31'h0000_0000);
    send_request(btmx_pkg::REQ_QUERY,  31'h2AAA_AAAA);
    send_request(btmx_pkg::REQ_INSERT, 31'h5555_5555);
    send_request(btmx_pkg::REQ_QUERY,  31'h5555_5555);
    send_request(btmx_pkg::REQ_INSERT, 31'h0000_0001);
    send_request(btmx_pkg::REQ_INSERT, 31'h4000_0000);
    send_request(btmx_pkg::REQ_QUERY,  31'h3FFF_FFFF);
    send_request(btmx_pkg::REQ_QUERY,  31'h4000_0001);
    send_request(btmx_pkg::REQ_INSERT, 31'h7FFF_FFFE);
    send_request(btmx_pkg::REQ_QUERY,  31'h0000_0001);
    send_request(btmx_pkg::REQ_INSERT, 31'h5555_5555);
    send_request(btmx_pkg::REQ_QUERY,  31'h1234_5678);
    key_pool.insert(key_pool.size(), 31'h0000_0000);
    key_pool.insert(key_pool.size(), 31'h7FFF_FFFF);
    key_pool.insert(key_pool.size(), 31'h5555_5555);
    drain_answers();

    sent = 0;
    while (sent < RAND_ITEMS) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && sent < RAND_ITEMS; i++) begin
        sel = $urandom_range(0, 99);
        low_mask = (31'd1 << $urandom_range(1, 12)) - 31'd1;
        if ($urandom_range(0, 99) < 45) begin
          kind = btmx_pkg::REQ_INSERT;
          if (sel < 50)
            key = KEY_W'($urandom);
          else if (sel < 75)
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
          else
            key = key_pool[$urandom_range(0, key_pool.size() - 1)] ^
                  (KEY_W'($urandom) & low_mask);
          key_pool.insert(key_pool.size(), key);
        end else begin
          kind = btmx_pkg::REQ_QUERY;
          if (sel < 50)
            key = KEY_W'($urandom);
          else
            key = key_pool[$urandom_range(0, key_pool.size() - 1)] ^
                  (KEY_W'($urandom) & low_mask);
        end
        send_request(kind, key);
        sent++;
        if (sent == RAND_ITEMS / 2) drain_answers();
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end

    req_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("binary_trie_max_xor: match");
    end else begin
      $display("binary_trie_max_xor: mismatch");
    end
    $finish;
  end

endmodule
